FILE: rtl/rpc_pkg.sv
package rpc_pkg;

  localparam int MAX_RECTS     = 64;
  localparam int DIM_BITS      = 11;
  localparam int POS_BITS      = DIM_BITS + 1;
  localparam int AREA_BITS     = 2 * DIM_BITS;
  localparam int IDX_BITS      = $clog2(MAX_RECTS);
  localparam int CNT_BITS      = $clog2(MAX_RECTS + 1);
  localparam int TAG_BITS      = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_BIN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BIN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BIN_NUMBER = 2'd2;

  localparam logic [DIM_BITS-1:0]  RESET_BIN_WIDTH  = DIM_BITS'(1024);
  localparam logic [DIM_BITS-1:0]  RESET_BIN_HEIGHT = DIM_BITS'(1024);
  localparam logic [TAG_BITS-1:0]  RESET_BIN_NUMBER = '0;
  localparam logic [AREA_BITS-1:0] RESET_FREE_AREA  = AREA_BITS'(1024 * 1024);

  typedef struct packed {
    logic [DIM_BITS-1:0]        rect_width;
    logic [DIM_BITS-1:0]        rect_height;
    logic                       rotated;
    logic signed [POS_BITS-1:0] pos_x;
    logic signed [POS_BITS-1:0] pos_y;
  } rpc_in_t;

  typedef struct packed {
    logic                 accepted;
    logic                 table_full;
    logic [AREA_BITS-1:0] free_area;
    logic [CNT_BITS-1:0]  placed_count;
    logic [TAG_BITS-1:0]  bin_tag;
  } rpc_out_t;

  // One stored placement: position and size after rotation.
  typedef struct packed {
    logic [DIM_BITS-1:0] x;
    logic [DIM_BITS-1:0] y;
    logic [DIM_BITS-1:0] w;
    logic [DIM_BITS-1:0] h;
  } rpc_entry_t;

  localparam int ENTRY_BITS = $bits(rpc_entry_t);

endpackage

FILE: rtl/rpc_rect_ram.sv
module rpc_rect_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [rpc_pkg::IDX_BITS-1:0] waddr,
  input  rpc_pkg::rpc_entry_t          wdata,
  input  logic                         re,
  input  logic [rpc_pkg::IDX_BITS-1:0] raddr,
  output rpc_pkg::rpc_entry_t          rdata
);

  logic [rpc_pkg::ENTRY_BITS-1:0] mem [rpc_pkg::MAX_RECTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/rpc_overlap.sv
module rpc_overlap (
  input  rpc_pkg::rpc_entry_t cand,
  input  rpc_pkg::rpc_entry_t stored,
  output logic                hit
);

  logic [rpc_pkg::POS_BITS-1:0] cand_x0, cand_x1, cand_y0, cand_y1;
  logic [rpc_pkg::POS_BITS-1:0] st_x0, st_x1, st_y0, st_y1;

  // Half-open intervals: rectangles that only share an edge do not collide.
  always_comb begin
    cand_x0 = {1'b0, cand.x};
    cand_y0 = {1'b0, cand.y};
    cand_x1 = {1'b0, cand.x} + {1'b0, cand.w};
    cand_y1 = {1'b0, cand.y} + {1'b0, cand.h};
    st_x0   = {1'b0, stored.x};
    st_y0   = {1'b0, stored.y};
    st_x1   = {1'b0, stored.x} + {1'b0, stored.w};
    st_y1   = {1'b0, stored.y} + {1'b0, stored.h};
    hit     = (cand_x0 < st_x1) && (cand_x1 > st_x0) &&
              (cand_y0 < st_y1) && (cand_y1 > st_y0);
  end

endmodule

FILE: rtl/rect_placement_checker_unit.sv
// Placement checker for one bin. Each input transaction asks to place a
// rectangle; exactly one result transaction follows it. A request that passes
// the table, bounds and area checks goes through the check, scan, write and
// finish states, the scan covering the N stored rectangles (at most 63
// while the table has room; none when it is empty): the store is one memory
// with a single read port, so one stored rectangle is compared per cycle.
// The scan stops at the first overlap, which rejects the request. Requests
// rejected for a full table, a negative position, the bin bounds or free
// area skip the scan and go from the check state straight to finish. The
// finish state waits while the output register holds a stalled earlier result.
// The input stalls from acceptance until the result is loaded into the output
// register, and the next request can be accepted at the following edge, even
// if that result has not yet been taken. Writing any configuration register
// empties the store and reloads the free area with the bin width times the
// bin height.
module rect_placement_checker_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rpc_pkg::rpc_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rpc_pkg::rpc_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [rpc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [rpc_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_WRITE  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state, state_next;

  logic [rpc_pkg::DIM_BITS-1:0]  bin_w, bin_h;
  logic [rpc_pkg::TAG_BITS-1:0]  bin_number;
  logic [rpc_pkg::CNT_BITS-1:0]  count;
  logic [rpc_pkg::AREA_BITS-1:0] free_area;

  // Current request.
  logic                          neg_pos;
  rpc_pkg::rpc_entry_t           cand;
  logic [rpc_pkg::AREA_BITS-1:0] area;
  logic                          ok;
  logic                          full;
  logic [rpc_pkg::IDX_BITS-1:0]  scan_idx;

  logic                          accept_in;
  logic                          cfg_hit;
  logic [rpc_pkg::DIM_BITS-1:0]  new_width, new_height;

  logic                          fail_early;
  logic                          is_full;
  logic                          last;
  logic                          hit;
  logic                          load_out;

  logic                          ram_we, ram_re;
  logic [rpc_pkg::IDX_BITS-1:0]  ram_raddr;
  rpc_pkg::rpc_entry_t           ram_rdata;

  assign accept_in = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);

  assign cfg_hit    = cfg_we && (cfg_index == rpc_pkg::REG_BIN_WIDTH ||
                                 cfg_index == rpc_pkg::REG_BIN_HEIGHT ||
                                 cfg_index == rpc_pkg::REG_BIN_NUMBER);
  assign new_width  = (cfg_index == rpc_pkg::REG_BIN_WIDTH) ?
                      cfg_data[rpc_pkg::DIM_BITS-1:0] : bin_w;
  assign new_height = (cfg_index == rpc_pkg::REG_BIN_HEIGHT) ?
                      cfg_data[rpc_pkg::DIM_BITS-1:0] : bin_h;

  always_comb begin
    is_full    = (count >= rpc_pkg::CNT_BITS'(rpc_pkg::MAX_RECTS));
    fail_early = is_full || neg_pos ||
                 (({1'b0, cand.x} + {1'b0, cand.w}) > {1'b0, bin_w}) ||
                 (({1'b0, cand.y} + {1'b0, cand.h}) > {1'b0, bin_h}) ||
                 (area > free_area);
    last       = ((rpc_pkg::CNT_BITS'(scan_idx) + rpc_pkg::CNT_BITS'(1)) == count);
    load_out   = (state == ST_FINISH) && (!out_valid || !out_stall);
  end

  rpc_overlap u_overlap (
    .cand   (cand),
    .stored (ram_rdata),
    .hit    (hit)
  );

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = (state == ST_WRITE);
    case (state)
      ST_CHECK: begin
        ram_re = !fail_early && (count != '0);
      end
      ST_SCAN: begin
        ram_re    = !hit && !last;
        ram_raddr = scan_idx + rpc_pkg::IDX_BITS'(1);
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  rpc_rect_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[rpc_pkg::IDX_BITS-1:0]),
    .wdata (cand),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept_in) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (fail_early) begin
          state_next = ST_FINISH;
        end else if (count == '0) begin
          state_next = ST_WRITE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = ST_FINISH;
        end else if (last) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      bin_w      <= rpc_pkg::RESET_BIN_WIDTH;
      bin_h      <= rpc_pkg::RESET_BIN_HEIGHT;
      bin_number <= rpc_pkg::RESET_BIN_NUMBER;
      count      <= '0;
      free_area  <= rpc_pkg::RESET_FREE_AREA;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_hit) begin
        bin_w <= new_width;
        bin_h <= new_height;
        if (cfg_index == rpc_pkg::REG_BIN_NUMBER) begin
          bin_number <= cfg_data[rpc_pkg::TAG_BITS-1:0];
        end
        count     <= '0;
        free_area <= {{rpc_pkg::DIM_BITS{1'b0}}, new_width} *
                     {{rpc_pkg::DIM_BITS{1'b0}}, new_height};
      end else if (state == ST_WRITE) begin
        count     <= count + rpc_pkg::CNT_BITS'(1);
        free_area <= free_area - area;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      neg_pos <= in_data.pos_x[rpc_pkg::POS_BITS-1] || in_data.pos_y[rpc_pkg::POS_BITS-1];
      cand.x  <= in_data.pos_x[rpc_pkg::DIM_BITS-1:0];
      cand.y  <= in_data.pos_y[rpc_pkg::DIM_BITS-1:0];
      cand.w  <= in_data.rotated ? in_data.rect_height : in_data.rect_width;
      cand.h  <= in_data.rotated ? in_data.rect_width : in_data.rect_height;
      area    <= {{rpc_pkg::DIM_BITS{1'b0}}, in_data.rect_width} *
                 {{rpc_pkg::DIM_BITS{1'b0}}, in_data.rect_height};
      ok      <= 1'b0;
    end
    if (state == ST_CHECK) begin
      full     <= is_full;
      scan_idx <= '0;
    end
    if (state == ST_SCAN && !hit && !last) begin
      scan_idx <= scan_idx + rpc_pkg::IDX_BITS'(1);
    end
    if (state == ST_WRITE) begin
      ok <= 1'b1;
    end
    if (load_out) begin
      out_data.accepted     <= ok;
      out_data.table_full   <= full;
      out_data.free_area    <= free_area;
      out_data.placed_count <= count;
      out_data.bin_tag      <= ok ? bin_number : '0;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= rpc_pkg::CNT_BITS'(rpc_pkg::MAX_RECTS))
    else $error("store count beyond capacity");

  a_write_counts: assert property (@(posedge clk) disable iff (rst)
    (ram_we && !cfg_hit) |=> (count == $past(count) + rpc_pkg::CNT_BITS'(1)))
    else $error("store write did not advance the count");

  a_accept_not_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.accepted) |->
      (!out_data.table_full && out_data.placed_count != '0))
    else $error("accepted placement reported with a full or empty store");

  a_reject_no_tag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.accepted) |-> (out_data.bin_tag == '0))
    else $error("rejected placement carries a bin tag");

  a_write_not_full: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (count < rpc_pkg::CNT_BITS'(rpc_pkg::MAX_RECTS)))
    else $error("store written while full");
`endif

endmodule
